[rtl/core/kst_pkg.sv]
// Shared types and constants of the keyed semaphore table.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package kst_pkg;

  typedef enum logic [2:0] {
    FN_CREATE   = 3'd0,
    FN_GETID    = 3'd1,
    FN_ATTACH   = 3'd2,
    FN_SET      = 3'd3,
    FN_GETCOUNT = 3'd4,
    FN_DELETE   = 3'd5,
    FN_DOWN     = 3'd6,
    FN_UP       = 3'd7
  } func_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_NOT_FOUND     = 3'd1,
    ST_ACCESS_DENIED = 3'd2,
    ST_KEY_EXISTS    = 3'd3,
    ST_NO_SPACE      = 3'd4,
    ST_WOULD_BLOCK   = 3'd5
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic fetch;
    logic exec;
  } ctrl_cmd_t;

  localparam logic [15:0] CountMax = 16'hFFFF;

endpackage

[rtl/core/kst_ctrl.sv]
// Controller state machine of the keyed semaphore table.
// Depends on kst_pkg; drives the datapath commands and the handshake outputs.
`timescale 1ns / 1ps

module kst_ctrl import kst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output logic      done_o,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) state_q <= S_FETCH;
        end
        S_FETCH: begin
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign cmd_o.capture = start_i && (state_q == S_IDLE);
  assign cmd_o.fetch   = (state_q == S_FETCH);
  assign cmd_o.exec    = (state_q == S_EXEC);

endmodule

[rtl/core/kst_dp.sv]
// Datapath of the keyed semaphore table: slot registers, user row memory
// and the request evaluation. Depends on kst_pkg.
`timescale 1ns / 1ps

module kst_dp import kst_pkg::*; #(
  parameter int NUM_SLOTS = 16,
  parameter int NUM_USERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_cmd_t   cmd_i,
  input  logic [2:0]  func_i,
  input  logic [7:0]  pid_i,
  input  logic [3:0]  slot_i,
  input  logic [31:0] key_i,
  input  logic [15:0] set_count_i,
  output logic [2:0]  status_o,
  output logic [15:0] value_o
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int UW = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;

  typedef struct packed {
    logic [NUM_USERS-1:0]      vld;
    logic [NUM_USERS-1:0][7:0] pid;
  } user_row_t;

  // Captured request.
  func_e       func_q;
  logic [7:0]  pid_q;
  logic [3:0]  slot_q;
  logic [31:0] key_q;
  logic [15:0] newc_q;

  // Slot table.
  logic [NUM_SLOTS-1:0]        active_q;
  logic [NUM_SLOTS-1:0][31:0]  skey_q;
  logic [NUM_SLOTS-1:0][7:0]   owner_q;
  logic [NUM_SLOTS-1:0][15:0]  count_q;
  logic [NUM_SLOTS-1:0]        row_vld_q;

  // User rows, one per slot.
  user_row_t user_mem [NUM_SLOTS];
  user_row_t row_raw_q;

  // Fetch stage results.
  logic [NUM_SLOTS-1:0] match_q;
  logic                 rv_q;
  logic                 live_q;
  logic                 owner_hit_q;
  logic [15:0]          cnt_q;

  logic [2:0]  status_q;
  logic [15:0] value_q;

  logic [SW-1:0] sidx;
  assign sidx = SW'(slot_q);

  // Execute stage.
  user_row_t     row_eff, row_new;
  logic          key_any, free_any, user_hit, empty_any;
  logic [SW-1:0] key_idx, free_idx;
  logic [UW-1:0] user_idx, empty_idx;
  status_e       st;
  logic [15:0]   val;
  logic          do_create, do_row_wr, do_cnt_wr, do_free;
  logic [15:0]   cnt_new;

  always_comb begin
    row_eff   = rv_q ? row_raw_q : '0;
    key_any   = 1'b0;
    key_idx   = '0;
    free_any  = 1'b0;
    free_idx  = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (match_q[s]) begin
        key_any = 1'b1;
        key_idx = SW'(s);
      end
      if (!active_q[s]) begin
        free_any = 1'b1;
        free_idx = SW'(s);
      end
    end
    user_hit  = 1'b0;
    user_idx  = '0;
    empty_any = 1'b0;
    empty_idx = '0;
    for (int u = NUM_USERS - 1; u >= 0; u--) begin
      if (row_eff.vld[u] && (row_eff.pid[u] == pid_q)) begin
        user_hit = 1'b1;
        user_idx = UW'(u);
      end
      if (!row_eff.vld[u]) begin
        empty_any = 1'b1;
        empty_idx = UW'(u);
      end
    end

    st        = ST_OK;
    val       = '0;
    do_create = 1'b0;
    do_row_wr = 1'b0;
    do_cnt_wr = 1'b0;
    do_free   = 1'b0;
    cnt_new   = cnt_q;
    row_new   = row_eff;

    unique case (func_q)
      FN_CREATE: begin
        if (key_any) begin
          st = ST_KEY_EXISTS;
        end else if (free_any) begin
          do_create = 1'b1;
          val       = 16'(free_idx);
        end else begin
          st = ST_NO_SPACE;
        end
      end
      FN_GETID: begin
        if (key_any) val = 16'(key_idx);
        else         st  = ST_NOT_FOUND;
      end
      FN_ATTACH: begin
        if (!live_q) begin
          st = ST_NOT_FOUND;
        end else if (owner_hit_q || user_hit) begin
          val = 16'(slot_q);
        end else if (empty_any) begin
          row_new.vld[empty_idx] = 1'b1;
          row_new.pid[empty_idx] = pid_q;
          do_row_wr = 1'b1;
          val       = 16'(slot_q);
        end else begin
          st = ST_NO_SPACE;
        end
      end
      FN_SET, FN_GETCOUNT, FN_DELETE: begin
        if (!live_q) begin
          st = ST_NOT_FOUND;
        end else if (!(owner_hit_q || user_hit)) begin
          st = ST_ACCESS_DENIED;
        end else if (func_q == FN_SET) begin
          do_cnt_wr = 1'b1;
          cnt_new   = newc_q;
        end else if (func_q == FN_GETCOUNT) begin
          val = cnt_q;
        end else if (owner_hit_q) begin
          do_free = 1'b1;
        end else begin
          row_new.vld[user_idx] = 1'b0;
          do_row_wr = 1'b1;
        end
      end
      FN_DOWN: begin
        if (!live_q) begin
          st = ST_NOT_FOUND;
        end else if (cnt_q == 16'd0) begin
          st = ST_WOULD_BLOCK;
        end else begin
          do_cnt_wr = 1'b1;
          cnt_new   = cnt_q - 16'd1;
        end
      end
      FN_UP: begin
        if (!live_q) begin
          st = ST_NOT_FOUND;
        end else if (cnt_q != CountMax) begin
          do_cnt_wr = 1'b1;
          cnt_new   = cnt_q + 16'd1;
        end
      end
      default: begin
        st = ST_NOT_FOUND;
      end
    endcase
  end

  // Request capture, fetch stage and result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_e'(func_i);
      pid_q  <= pid_i;
      slot_q <= slot_i;
      key_q  <= key_i;
      newc_q <= set_count_i;
    end
    if (cmd_i.fetch) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        match_q[s] <= active_q[s] && (skey_q[s] == key_q);
      end
      row_raw_q   <= user_mem[sidx];
      rv_q        <= row_vld_q[sidx];
      live_q      <= (32'(slot_q) < NUM_SLOTS) && active_q[sidx];
      owner_hit_q <= (owner_q[sidx] == pid_q);
      cnt_q       <= count_q[sidx];
    end
    if (cmd_i.exec) begin
      status_q <= st;
      value_q  <= val;
    end
  end

  // User row memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && do_row_wr) user_mem[sidx] <= row_new;
  end

  // Key and owner of a slot are only looked at while the slot is active.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && do_create) begin
      skey_q[free_idx]  <= key_q;
      owner_q[free_idx] <= pid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= '0;
      count_q   <= '0;
      row_vld_q <= '0;
    end else if (cmd_i.exec) begin
      if (do_create) begin
        active_q[free_idx]  <= 1'b1;
        row_vld_q[free_idx] <= 1'b0;
      end
      if (do_free)   active_q[sidx]  <= 1'b0;
      if (do_row_wr) row_vld_q[sidx] <= 1'b1;
      if (do_cnt_wr) count_q[sidx]   <= cnt_new;
    end
  end

  assign status_o = status_q;
  assign value_o  = value_q;

endmodule

[rtl/core/keyed_semaphore_table_unit.sv]
// Top level of the keyed semaphore table.
// Depends on kst_pkg, kst_ctrl and kst_dp.
`timescale 1ns / 1ps

// Usage:
// A request item is accepted at a rising edge where start_i is high and busy_o
// is low. It carries an operation code, the requesting process id, a slot
// index, a key and a new count value. Each request yields exactly one result
// item, shown on status_o and value_o for one cycle while done_o is high.
// The receiver cannot stall, so the result is simply taken in that cycle.
// The accepting edge registers the request, the fetch cycle reads the slot
// entry and the user row of the slot from the row memory and compares the key
// against every slot, and the execute cycle evaluates the request, writes the
// tables back and registers the result together with done_o. The block
// handles one item at a time: busy_o stays high from the accepting edge until
// the result is registered.
// Reset makes every slot inactive, zeroes the counts and marks every user row
// empty through a per-row valid bit, so no clearing pass is needed and a
// request may start in the first cycle after reset.
module keyed_semaphore_table_unit import kst_pkg::*; #(
  parameter int NUM_SLOTS = 16,
  parameter int NUM_USERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  func_i,
  input  logic [7:0]  pid_i,
  input  logic [3:0]  slot_i,
  input  logic [31:0] key_i,
  input  logic [15:0] set_count_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [15:0] value_o
);

  ctrl_cmd_t cmd;

  // The controller sequences capture, fetch and execute.
  kst_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  // The datapath holds all table state and forms the result.
  kst_dp #(
    .NUM_SLOTS (NUM_SLOTS),
    .NUM_USERS (NUM_USERS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .func_i      (func_i),
    .pid_i       (pid_i),
    .slot_i      (slot_i),
    .key_i       (key_i),
    .set_count_i (set_count_i),
    .status_o    (status_o),
    .value_o     (value_o)
  );

endmodule

[verif/keyed_semaphore_table_unit_test.sv]
// Self-checking bench for the keyed semaphore table: directed and random requests,
// each result compared with a behavioral prediction of the table.
// Depends on kst_pkg and the keyed_semaphore_table_unit RTL.
`timescale 1ns / 1ps

module keyed_semaphore_table_unit_test;
  import kst_pkg::*;

  localparam int NSLOT = 16;
  localparam int NUSER = 16;

  typedef struct packed {
    func_e       func;
    logic [7:0]  pid;
    logic [3:0]  slot;
    logic [31:0] key;
    logic [15:0] newc;
  } request_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] value;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [2:0]  func_i = '0;
  logic [7:0]  pid_i = '0;
  logic [3:0]  slot_i = '0;
  logic [31:0] key_i = '0;
  logic [15:0] set_count_i = '0;
  logic        busy_o, done_o;
  logic [2:0]  status_o;
  logic [15:0] value_o;

  keyed_semaphore_table_unit dut (.*);

  // Shadow copy of the table that the bench predicts with.
  logic        tbl_active [NSLOT];
  logic [31:0] tbl_key    [NSLOT];
  logic [7:0]  tbl_owner  [NSLOT];
  logic [15:0] tbl_count  [NSLOT];
  logic        usr_valid  [NSLOT][NUSER];
  logic [7:0]  usr_pid    [NSLOT][NUSER];

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  int       errors = 0;
  bit       stimulus_done = 1'b0;
  bit       quiet_phase = 1'b0;
  bit       hold_for_drain = 1'b0;

  // Small key pool so that create and getid hit existing keys often.
  logic [31:0] key_pool[8] = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000,
                               32'h5555_AAAA, 32'h1234_5678, 32'hAAAA_5555, 32'h7};

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int lookup_key(logic [31:0] k);
    for (int s = 0; s < NSLOT; s++)
      if (tbl_active[s] && tbl_key[s] == k) return s;
    return -1;
  endfunction

  function automatic int lookup_user(int s, logic [7:0] p);
    for (int u = 0; u < NUSER; u++)
      if (usr_valid[s][u] && usr_pid[s][u] == p) return u;
    return -1;
  endfunction

  // Applies one request to the shadow table and returns the answer it must give.
  function automatic answer_t predict_answer(request_t r);
    answer_t a;
    int s, f, u;
    bit live, allowed;
    s = r.slot;
    a.status = ST_OK;
    a.value = '0;
    live = (s < NSLOT) && tbl_active[s];
    allowed = live && (tbl_owner[s] == r.pid || lookup_user(s, r.pid) >= 0);
    case (r.func)
      FN_CREATE: begin
        if (lookup_key(r.key) >= 0) a.status = ST_KEY_EXISTS;
        else begin
          a.status = ST_NO_SPACE;
          for (f = 0; f < NSLOT; f++) begin
            if (!tbl_active[f]) begin
              tbl_active[f] = 1'b1;
              tbl_key[f] = r.key;
              tbl_owner[f] = r.pid;
              // The count deliberately keeps its old value.
              for (u = 0; u < NUSER; u++) begin
                usr_valid[f][u] = 1'b0;
                usr_pid[f][u] = '0;
              end
              a.status = ST_OK;
              a.value = 16'(f);
              break;
            end
          end
        end
      end
      FN_GETID: begin
        f = lookup_key(r.key);
        if (f < 0) a.status = ST_NOT_FOUND;
        else a.value = 16'(f);
      end
      FN_ATTACH: begin
        if (!live) a.status = ST_NOT_FOUND;
        else if (allowed) a.value = 16'(s);
        else begin
          a.status = ST_NO_SPACE;
          for (u = 0; u < NUSER; u++) begin
            if (!usr_valid[s][u]) begin
              usr_valid[s][u] = 1'b1;
              usr_pid[s][u] = r.pid;
              a.status = ST_OK;
              a.value = 16'(s);
              break;
            end
          end
        end
      end
      FN_SET, FN_GETCOUNT, FN_DELETE: begin
        if (!live) a.status = ST_NOT_FOUND;
        else if (!allowed) a.status = ST_ACCESS_DENIED;
        else if (r.func == FN_SET) tbl_count[s] = r.newc;
        else if (r.func == FN_GETCOUNT) a.value = tbl_count[s];
        else if (tbl_owner[s] == r.pid) tbl_active[s] = 1'b0;
        else begin
          u = lookup_user(s, r.pid);
          if (u >= 0) usr_valid[s][u] = 1'b0;
        end
      end
      FN_DOWN: begin
        if (!live) a.status = ST_NOT_FOUND;
        else if (tbl_count[s] == '0) a.status = ST_WOULD_BLOCK;
        else tbl_count[s] = tbl_count[s] - 16'd1;
      end
      default: begin
        if (!live) a.status = ST_NOT_FOUND;
        else if (tbl_count[s] != CountMax) tbl_count[s] = tbl_count[s] + 16'd1;
      end
    endcase
    if (a.status != ST_OK) a.value = '0;
    return a;
  endfunction

  function automatic request_t make_request(func_e f, logic [7:0] p, logic [3:0] s,
                                            logic [31:0] k, logic [15:0] c);
    request_t r;
    r.func = f; r.pid = p; r.slot = s; r.key = k; r.newc = c;
    return r;
  endfunction

  // Random request biased toward a few pids, pooled keys and edge-case counts.
  function automatic request_t random_request();
    request_t r;
    r.func = func_e'($urandom_range(0, 7));
    r.pid = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 5)) : 8'($urandom);
    r.slot = 4'($urandom);
    r.key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 7)] : $urandom;
    case ($urandom_range(0, 3))
      0: r.newc = '0;
      1: r.newc = CountMax - 16'($urandom_range(0, 2));
      2: r.newc = 16'($urandom_range(0, 3));
      default: r.newc = 16'($urandom);
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Driver: presents the next pending item and holds it until accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_answers.push_back(predict_answer(pending_reqs.pop_front()));
      end
      if (pending_reqs.size() != 0 && !hold_for_drain &&
          (quiet_phase || $urandom_range(0, 99) >= 29)) begin
        start_i     <= 1'b1;
        func_i      <= pending_reqs[0].func;
        pid_i       <= pending_reqs[0].pid;
        slot_i      <= pending_reqs[0].slot;
        key_i       <= pending_reqs[0].key;
        set_count_i <= pending_reqs[0].newc;
      end else if (!(start_i && busy_o)) begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: every done strobe must match the oldest expectation.
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && done_o) begin
      if (expected_answers.size() == 0) begin
        report_mismatch("result count", 1, 0);
      end else begin
        want = expected_answers.pop_front();
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (value_o !== want.value) report_mismatch("value", value_o, want.value);
      end
    end
  end

  initial begin
    for (int s = 0; s < NSLOT; s++) begin
      tbl_active[s] = 1'b0; tbl_key[s] = '0; tbl_owner[s] = '0; tbl_count[s] = '0;
      for (int u = 0; u < NUSER; u++) begin
        usr_valid[s][u] = 1'b0; usr_pid[s][u] = '0;
      end
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: inactive slots, create, duplicate key, access rules,
    // up saturation, down at zero, delete by user and by owner.
    pending_reqs.push_back(make_request(FN_GETID,  8'h00, 4'h0, 32'hFFFF_FFFF, 16'h0));
    pending_reqs.push_back(make_request(FN_UP,     8'h00, 4'hF, 32'h0, 16'h0));
    pending_reqs.push_back(make_request(FN_CREATE, 8'hFF, 4'h0, 32'hFFFF_FFFF, 16'h0));
    pending_reqs.push_back(make_request(FN_CREATE, 8'h01, 4'h0, 32'hFFFF_FFFF, 16'h0));
    pending_reqs.push_back(make_request(FN_GETID,  8'h01, 4'h0, 32'hFFFF_FFFF, 16'h0));
    pending_reqs.push_back(make_request(FN_SET,    8'h01, 4'h0, 32'h0, 16'hFFFF));
    pending_reqs.push_back(make_request(FN_ATTACH, 8'h01, 4'h0, 32'h0, 16'h0));
    pending_reqs.push_back(make_request(FN_SET,    8'h01, 4'h0, 32'h0, 16'hFFFE));
    pending_reqs.push_back(make_request(FN_SET,    8'hFF, 4'h0, 32'h0, 16'hFFFE));
    pending_reqs.push_back(make_request(FN_UP,     8'h00, 4'h0, 32'h0, 16'h0));
    pending_reqs.push_back(make_request(FN_UP,     8'h00, 4'h0, 32'h0, 16'h0));
    pending_reqs.push_back(make_request(FN_GETCOUNT, 8'h01, 4'h0, 32'h0, 16'h0));
    pending_reqs.push_back(make_request(FN_SET,    8'h01, 4'h0, 32'h0, 16'h0001));
    pending_reqs.push_back(make_request(FN_DOWN,   8'h09, 4'h0, 32'h0, 16'h0));
    pending_reqs.push_back(make_request(FN_DOWN,   8'h09, 4'h0, 32'h0, 16'h0));
    pending_reqs.push_back(make_request(FN_DELETE, 8'h01, 4'h0, 32'h0, 16'h0));
    pending_reqs.push_back(make_request(FN_DELETE, 8'h01, 4'h0, 32'h0, 16'h0));
    pending_reqs.push_back(make_request(FN_DELETE, 8'hFF, 4'h0, 32'h0, 16'h0));
    pending_reqs.push_back(make_request(FN_GETCOUNT, 8'hFF, 4'h0, 32'h0, 16'h0));
    pending_reqs.push_back(make_request(FN_CREATE, 8'h00, 4'h0, 32'h0, 16'h0));
    pending_reqs.push_back(make_request(FN_GETCOUNT, 8'h00, 4'h0, 32'h0, 16'h0));
    // Fill the table, then overflow it and a user row.
    for (int i = 1; i <= NSLOT; i++)
      pending_reqs.push_back(make_request(FN_CREATE, 8'h02, 4'h0, 32'h100 + i, 16'h0));
    for (int i = 0; i <= NUSER; i++)
      pending_reqs.push_back(make_request(FN_ATTACH, 8'(8'h10 + i), 4'h5, 32'h0, 16'h0));
    for (int i = 0; i < NSLOT; i++)
      pending_reqs.push_back(make_request(FN_DELETE, 8'h02, 4'(i), 32'h0, 16'h0));

    // Drain completely once before the random part.
    wait (pending_reqs.size() == 0);
    hold_for_drain = 1'b1;
    wait (expected_answers.size() == 0);
    hold_for_drain = 1'b0;

    for (int i = 0; i < 1800; i++) begin
      if (pending_reqs.size() > 16) wait (pending_reqs.size() <= 16);
      quiet_phase = (i >= 600 && i < 900);
      pending_reqs.push_back(random_request());
    end
    wait (pending_reqs.size() == 0 && expected_answers.size() == 0);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

endmodule
